[design/lru_pkg.sv]
package lru_pkg;

  localparam int WAYS      = 8;
  localparam int AGE_BITS  = 16;
  localparam int ADDR_BITS = 16;

  localparam int IDX_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int FILL_BITS = $clog2(WAYS + 1);
  localparam int CNT_BITS  = $clog2(ADDR_BITS + WAYS + 1);
  localparam int LIM_BITS  = 33;

  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  localparam logic [1:0] REG_CAPACITY    = 2'd0;
  localparam logic [1:0] REG_BLOCK_COUNT = 2'd1;
  localparam logic [1:0] REG_WORD_SIZE   = 2'd2;

  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] block;
    logic [AGE_BITS-1:0]  age;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic update;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_UPD
  } state_e;

endpackage

[design/lru_in_if.sv]
interface lru_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] address;

  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

[design/lru_out_if.sv]
interface lru_out_if;
  logic        valid;
  logic        ready;
  logic        bad_address;
  logic        hit;
  logic [15:0] block_number;
  logic        evicted;
  logic [15:0] victim_block;
  logic [15:0] victim_age;
  logic [3:0]  filled;

  modport source (output valid, output bad_address, output hit, output block_number,
                  output evicted, output victim_block, output victim_age, output filled,
                  input ready);
  modport sink (input valid, input bad_address, input hit, input block_number,
                input evicted, input victim_block, input victim_age, input filled,
                output ready);
endinterface

[design/lru_cell.sv]
module lru_cell
  import lru_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_cmd_t            cmd_i,
  input  logic                 wr_i,
  input  logic [ADDR_BITS-1:0] blk_i,
  input  entry_t               next_i,
  output entry_t               ent_o
);

  entry_t ent_q, ent_d;

  always_comb begin
    ent_d = ent_q;
    if (cmd_i.shift) begin
      ent_d = next_i;
    end else if (cmd_i.update) begin
      if (ent_q.valid && ent_q.age != AGE_MAX) begin
        ent_d.age = ent_q.age + 1'b1;
      end
      if (wr_i) begin
        ent_d.valid = 1'b1;
        ent_d.block = blk_i;
        ent_d.age   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o = ent_q;

endmodule

[design/lru_cache_age_counter_top.sv]
// channel | dir | payload                                   | handshake
// in_i    | in  | address                                   | valid/ready
// out_o   | out | bad_address hit block_number evicted       | valid/ready
//         |     | victim_block victim_age filled            |
// cfg     | in  | APB: capacity 0x0, block_count 0x4, word_size 0x8 | pready tied high
// One beat runs 16 restoring-divide steps for the block number, then rotates
// each entry of the ring past the head cell for the hit/free/oldest search,
// then passes through the update state. A bad address skips to update.
// Reset clears the valid bits and fill count; no clearing pass.
// in_i is ready only when idle; the update cycle waits while out_o holds an unread beat.
module lru_cache_age_counter_top
  import lru_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  lru_in_if.sink      in_i,
  lru_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0]  capacity_q;
  logic [15:0] block_count_q;
  logic [8:0]  word_size_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q    <= 4'd8;
      block_count_q <= 16'd256;
      word_size_q   <= 9'd4;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_CAPACITY:    capacity_q    <= pwdata[3:0];
        REG_BLOCK_COUNT: block_count_q <= pwdata[15:0];
        REG_WORD_SIZE:   word_size_q   <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CAPACITY:    prdata = 32'(capacity_q);
      REG_BLOCK_COUNT: prdata = 32'(block_count_q);
      REG_WORD_SIZE:   prdata = 32'(word_size_q);
      default:         prdata = '0;
    endcase
  end

  // entry ring
  entry_t    ent [WAYS];
  cell_cmd_t cmd;
  logic [WAYS-1:0] wr;
  logic [ADDR_BITS-1:0] quo_q, quo_d;

  for (genvar i = 0; i < WAYS; i++) begin : g_cell
    lru_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .wr_i   (wr[i]),
      .blk_i  (quo_q),
      .next_i (ent[(i + 1) % WAYS]),
      .ent_o  (ent[i])
    );
  end

  state_e state_q, state_d;
  logic [CNT_BITS-1:0]  cnt_q, cnt_d;
  logic [ADDR_BITS-1:0] dvd_q, dvd_d;
  logic [9:0]           rem_q, rem_d;
  logic                 bad_q, bad_d;
  logic [FILL_BITS-1:0] fill_q, fill_d;

  logic                 hit_f_q, hit_f_d, free_f_q, free_f_d, best_f_q, best_f_d;
  logic [IDX_BITS-1:0]  hit_idx_q, hit_idx_d, free_idx_q, free_idx_d, best_idx_q, best_idx_d;
  logic [AGE_BITS-1:0]  best_age_q, best_age_d;
  logic [ADDR_BITS-1:0] best_blk_q, best_blk_d;

  logic                 ov_q, ov_d;
  logic                 o_bad_q, o_bad_d, o_hit_q, o_hit_d, o_ev_q, o_ev_d;
  logic [15:0]          o_blk_q, o_blk_d, o_vb_q, o_vb_d, o_va_q, o_va_d;
  logic [3:0]           o_fill_q, o_fill_d;

  logic [LIM_BITS-1:0]  limit;
  logic                 in_bad;
  logic [9:0]           trial;
  logic [FILL_BITS-1:0] cap_eff;
  logic [IDX_BITS-1:0]  slot, head_idx;
  entry_t               head;

  assign limit  = LIM_BITS'(block_count_q) * LIM_BITS'(word_size_q);
  assign in_bad = (word_size_q == '0) || (LIM_BITS'(in_i.address) >= limit);
  assign trial  = {rem_q[8:0], dvd_q[ADDR_BITS-1]};
  assign head   = ent[0];
  assign head_idx = cnt_q[IDX_BITS-1:0];

  always_comb begin
    if (capacity_q == '0) begin
      cap_eff = FILL_BITS'(1);
    end else if (8'(capacity_q) > 8'(WAYS)) begin
      cap_eff = FILL_BITS'(WAYS);
    end else begin
      cap_eff = FILL_BITS'(capacity_q);
    end
  end

  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    dvd_d = dvd_q;
    rem_d = rem_q;
    quo_d = quo_q;
    bad_d = bad_q;
    fill_d = fill_q;
    hit_f_d = hit_f_q;
    free_f_d = free_f_q;
    best_f_d = best_f_q;
    hit_idx_d = hit_idx_q;
    free_idx_d = free_idx_q;
    best_idx_d = best_idx_q;
    best_age_d = best_age_q;
    best_blk_d = best_blk_q;
    ov_d = ov_q && !out_o.ready;
    o_bad_d = o_bad_q;
    o_hit_d = o_hit_q;
    o_ev_d = o_ev_q;
    o_blk_d = o_blk_q;
    o_vb_d = o_vb_q;
    o_va_d = o_va_q;
    o_fill_d = o_fill_q;
    cmd = '0;
    wr = '0;
    slot = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          dvd_d = in_i.address;
          rem_d = '0;
          cnt_d = '0;
          bad_d = in_bad;
          hit_f_d = 1'b0;
          free_f_d = 1'b0;
          best_f_d = 1'b0;
          state_d = in_bad ? ST_UPD : ST_DIV;
        end
      end
      ST_DIV: begin
        if (trial >= {1'b0, word_size_q}) begin
          rem_d = trial - {1'b0, word_size_q};
          quo_d = {quo_q[ADDR_BITS-2:0], 1'b1};
        end else begin
          rem_d = trial;
          quo_d = {quo_q[ADDR_BITS-2:0], 1'b0};
        end
        dvd_d = {dvd_q[ADDR_BITS-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_BITS'(ADDR_BITS - 1)) begin
          cnt_d = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.shift = 1'b1;
        if (head.valid && head.block == quo_q && !hit_f_q) begin
          hit_f_d = 1'b1;
          hit_idx_d = head_idx;
        end
        if (!head.valid && !free_f_q) begin
          free_f_d = 1'b1;
          free_idx_d = head_idx;
        end
        if (head.valid && (!best_f_q || head.age > best_age_q ||
            (head.age == best_age_q && head.block < best_blk_q))) begin
          best_f_d = 1'b1;
          best_idx_d = head_idx;
          best_age_d = head.age;
          best_blk_d = head.block;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_BITS'(WAYS - 1)) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (!ov_q || out_o.ready) begin
          ov_d = 1'b1;
          o_bad_d = bad_q;
          o_hit_d = 1'b0;
          o_ev_d = 1'b0;
          o_blk_d = '0;
          o_vb_d = '0;
          o_va_d = '0;
          o_fill_d = 4'(fill_q);
          if (!bad_q) begin
            cmd.update = 1'b1;
            o_blk_d = 16'(quo_q);
            if (hit_f_q) begin
              slot = hit_idx_q;
              o_hit_d = 1'b1;
            end else if (fill_q < cap_eff) begin
              slot = free_idx_q;
              fill_d = fill_q + 1'b1;
              o_fill_d = 4'(fill_q + 1'b1);
            end else begin
              slot = best_idx_q;
              o_ev_d = 1'b1;
              o_vb_d = 16'(best_blk_q);
              o_va_d = 16'(best_age_q);
            end
            wr[slot] = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      ov_q    <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      ov_q    <= ov_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    bad_q <= bad_d;
    hit_f_q <= hit_f_d;
    free_f_q <= free_f_d;
    best_f_q <= best_f_d;
    hit_idx_q <= hit_idx_d;
    free_idx_q <= free_idx_d;
    best_idx_q <= best_idx_d;
    best_age_q <= best_age_d;
    best_blk_q <= best_blk_d;
    o_bad_q <= o_bad_d;
    o_hit_q <= o_hit_d;
    o_ev_q <= o_ev_d;
    o_blk_q <= o_blk_d;
    o_vb_q <= o_vb_d;
    o_va_q <= o_va_d;
    o_fill_q <= o_fill_d;
  end

  assign out_o.valid        = ov_q;
  assign out_o.bad_address  = o_bad_q;
  assign out_o.hit          = o_hit_q;
  assign out_o.block_number = o_blk_q;
  assign out_o.evicted      = o_ev_q;
  assign out_o.victim_block = o_vb_q;
  assign out_o.victim_age   = o_va_q;
  assign out_o.filled       = o_fill_q;

endmodule
